### rtl/core/cspq_pkg.sv
package cspq_pkg;

    localparam int SLOT_COUNT = 2;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [15:0] SETTLE_RESET = 16'd50;
    localparam logic [7:0]  READY_TUPLE  = 8'h1d;

    localparam logic FUNC_POLL  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'b01,
        PH_READY = 2'b10
    } phase_t;

    typedef struct packed {
        logic        func;
        logic        slot;
        logic        module_present;
        logic [7:0]  tuple_byte;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic present;
        logic ready_res;
        logic reset_pulse;
    } res_t;

endpackage

### rtl/core/cspq_if.sv
interface cspq_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        slot;
    logic        module_present;
    logic [7:0]  tuple_byte;
    logic [31:0] now;

    modport source (output valid, output func, output slot, output module_present,
                    output tuple_byte, output now, input ready);
    modport sink   (input valid, input func, input slot, input module_present,
                    input tuple_byte, input now, output ready);
endinterface

interface cspq_res_if;
    logic valid;
    logic ready;
    logic present;
    logic ready_res;
    logic reset_pulse;

    modport source (output valid, output present, output ready_res, output reset_pulse,
                    input ready);
    modport sink   (input valid, input present, input ready_res, input reset_pulse,
                    output ready);
endinterface

### rtl/core/cspq_slot_file.sv
module cspq_slot_file (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  cspq_pkg::req_t req,
    input  logic [15:0]   settle_ticks,
    output cspq_pkg::res_t res
);
    import cspq_pkg::*;

    phase_t      phase_reg    [SLOT_COUNT];
    logic [31:0] deadline_reg [SLOT_COUNT];
    logic        armed_reg    [SLOT_COUNT];

    phase_t      phase_next;
    logic [31:0] deadline_next;
    logic        armed_next;
    logic        slot_ok;
    logic        write_en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [31:0] diff;
    logic        past;

    assign slot_ok = 32'(req.slot) < SLOT_COUNT;
    assign idx     = SLOT_IDX_W'(req.slot);
    assign diff    = deadline_reg[idx] - req.now;
    assign past    = diff[31];

    always_comb
    begin
        phase_next    = phase_reg[idx];
        deadline_next = deadline_reg[idx];
        armed_next    = armed_reg[idx];
        write_en      = 1'b0;
        res           = '0;
        if (slot_ok)
        begin
            if (req.func == FUNC_RESET)
            begin
                if (req.module_present)
                begin
                    phase_next      = PH_IDLE;
                    deadline_next   = '0;
                    armed_next      = 1'b0;
                    write_en        = 1'b1;
                    res.reset_pulse = 1'b1;
                end
            end
            else if (req.module_present)
            begin
                res.present = 1'b1;
                write_en    = 1'b1;
                if (phase_reg[idx] == PH_IDLE)
                begin
                    if (!armed_reg[idx])
                    begin
                        deadline_next = req.now + 32'(settle_ticks);
                        armed_next    = 1'b1;
                    end
                    else if (past)
                    begin
                        if (req.tuple_byte == READY_TUPLE)
                        begin
                            phase_next = PH_READY;
                        end
                        else
                        begin
                            phase_next    = PH_IDLE;
                            deadline_next = '0;
                            armed_next    = 1'b0;
                        end
                    end
                end
                res.ready_res = (phase_next == PH_READY);
            end
            else
            begin
                phase_next    = PH_IDLE;
                deadline_next = '0;
                armed_next    = 1'b0;
                write_en      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                phase_reg[i]    <= PH_IDLE;
                deadline_reg[i] <= '0;
                armed_reg[i]    <= 1'b0;
            end
        end
        else if (step && write_en)
        begin
            phase_reg[idx]    <= phase_next;
            deadline_reg[idx] <= deadline_next;
            armed_reg[idx]    <= armed_next;
        end
    end

endmodule

### rtl/core/cam_slot_presence_qualifier_unit.sv
// An accepted word is captured in the input register, and its result word is then loaded
// into the result register; a stalled output holds both registers.
// Throughput: one word per cycle while the output is not stalled; the slot update and deadline compare sit in
// one stage between the input register and the result register.
// Reset: rst_n clears all slots to idle, disarms deadlines, empties both
// registers and loads settle_ticks with 50.
module cam_slot_presence_qualifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    cspq_req_if.sink    in_ch,
    cspq_res_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import cspq_pkg::*;

    logic [15:0] settle_reg;
    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    res_t        step_res;
    logic        out_load;
    logic        in_take;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || out_load;
    assign in_take = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_RESET;
        end
        else if (cfg_we)
        begin
            settle_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg.func           <= in_ch.func;
            s1_req_reg.slot           <= in_ch.slot;
            s1_req_reg.module_present <= in_ch.module_present;
            s1_req_reg.tuple_byte     <= in_ch.tuple_byte;
            s1_req_reg.now            <= in_ch.now;
        end
        if (out_load)
        begin
            out_res_reg <= step_res;
        end
    end

    cspq_slot_file u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (out_load),
        .req          (s1_req_reg),
        .settle_ticks (settle_reg),
        .res          (step_res)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.present     = out_res_reg.present;
    assign out_ch.ready_res   = out_res_reg.ready_res;
    assign out_ch.reset_pulse = out_res_reg.reset_pulse;

    a_ready_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (!out_ch.ready_res || out_ch.present))
        else $error("ready without module present");

    a_pulse_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.reset_pulse |-> !out_ch.present && !out_ch.ready_res)
        else $error("reset pulse mixed with poll result");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ch.ready)
        else $error("empty input stage refused a word");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted word lost from input stage");

endmodule
